// ===== sv/assert_macros.svh =====
// Assertion helpers, included by the top unit to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define STO_ASSERT(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) \
		else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define STO_NEVER(label, clk_s, rst_n, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== sv/sto_pkg.sv =====
package sto_pkg;

	// Field widths and fixed-point layout.
	localparam int FREQ_BITS      = 24;
	localparam int PERIOD_BITS    = 32;
	localparam int PROD_BITS      = FREQ_BITS + PERIOD_BITS;
	localparam int PROD_FRAC_BITS = 40;
	localparam int FRAC_BITS      = 16;

	// Configuration port.
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic REG_SAMPLE_PERIOD = 1'b0;
	localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = 32'd89478;

	// Phase queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	// Table build: pi/2 in Q30 and the Taylor term divisors (2n)(2n+1).
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} sto_q_stat_t;

	// sin(pi/2 * k / 2^qbits) scaled to peak, evaluated at elaboration.
	function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int qbits,
			input logic [63:0] peak);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		logic signed [63:0] sum;
		x = (k * HALF_PI_Q30 + (64'd1 << (qbits - 1))) >> qbits;
		x2 = (x * x) >> 30;
		t = x;
		sum = signed'(x);
		for (int n = 0; n < 8; n++) begin
			t = ((t * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0] == 1'b0) begin
				sum = sum - signed'(t);
			end else begin
				sum = sum + signed'(t);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (unsigned'(sum) * peak + (64'd1 << 29)) >> 30;
		if (v > peak) begin
			v = peak;
		end
		return v;
	endfunction

	// One entry of the full-wave table, built from quarter-wave symmetry.
	function automatic logic signed [31:0] rom_entry(input int i, input int addr_bits,
			input int sample_bits);
		int qbits;
		logic [63:0] q;
		logic [63:0] j;
		logic [63:0] k;
		logic [63:0] v;
		logic [1:0] quad;
		logic [63:0] peak;
		qbits = addr_bits - 2;
		q = 64'd1 << qbits;
		quad = 2'((i >> qbits) & 3);
		j = 64'(i) & (q - 64'd1);
		k = quad[0] ? (q - j) : j;
		peak = (64'd1 << (sample_bits - 1)) - 64'd1;
		v = quarter_sine(k, qbits, peak);
		return quad[1] ? -signed'(32'(v)) : signed'(32'(v));
	endfunction

endpackage

// ===== sv/sto_if.sv =====
// Frequency stream: one transfer per requested output sample.
interface sto_freq_if import sto_pkg::*; ();
	logic valid;
	logic ready;
	logic [FREQ_BITS-1:0] frequency;

	modport source(output valid, output frequency, input ready);
	modport sink(input valid, input frequency, output ready);
endinterface

// Sample stream: one interpolated sine value per transfer.
interface sto_sample_if #(parameter int SAMPLE_BITS = 16) ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

// ===== sv/sto_front.sv =====
// Front part: takes frequencies, forms the phase increment and owns the
// phase accumulator. Each item leaves with the phase it must be played at.
module sto_front import sto_pkg::*; #(
	parameter int PHASE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sto_freq_if.sink               freq,
	input  logic [PERIOD_BITS-1:0] period,
	input  sto_q_stat_t            q_stat,
	output logic                   push,
	output logic [PHASE_BITS-1:0]  push_phase
);

	logic [PROD_BITS-1:0]            prod;
	logic [PROD_BITS+PHASE_BITS-1:0] prod_ext;
	logic [PHASE_BITS-1:0]           inc;
	logic [PHASE_BITS-1:0]           inc_s1;
	logic                            valid_s1;
	logic [PHASE_BITS-1:0]           phase_q;
	logic                            accept;

	// Increment in turns: drop the integer part, align the fraction to the phase.
	always_comb begin
		prod = PROD_BITS'(freq.frequency) * PROD_BITS'(period);
		prod_ext = {prod, {PHASE_BITS{1'b0}}};
		inc = prod_ext[PROD_FRAC_BITS +: PHASE_BITS];
	end

	assign push = valid_s1 && !q_stat.full;
	assign freq.ready = !valid_s1 || !q_stat.full;
	assign accept = freq.valid && freq.ready;
	assign push_phase = phase_q;

	// Increment register in front of the accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inc_s1 <= inc;
		end
	end

	// The phase queued for an item is the sum of all earlier increments.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= phase_q + inc_s1;
		end
	end

endmodule

// ===== sv/sto_queue.sv =====
// Short phase queue that lets the front and back parts stall independently.
module sto_queue import sto_pkg::*; #(
	parameter int PHASE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [PHASE_BITS-1:0] push_phase,
	input  logic                  pop,
	output logic [PHASE_BITS-1:0] pop_phase,
	output sto_q_stat_t           q_stat
);

	logic [PHASE_BITS-1:0] slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;

	assign q_stat.full = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign pop_phase = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_phase;
		end
	end

endmodule

// ===== sv/sto_back.sv =====
// Back part: table lookup of two neighbor entries and linear interpolation.
// Stages: table read, difference, multiply, round and add into the output.
module sto_back import sto_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 11,
	parameter int PHASE_BITS      = 32,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sto_q_stat_t           q_stat,
	input  logic [PHASE_BITS-1:0] pop_phase,
	output logic                  pop,
	sto_sample_if.source          samp
);

	localparam int TableSize = 1 << TABLE_ADDR_BITS;
	localparam int RestBits  = PHASE_BITS - TABLE_ADDR_BITS;
	localparam int DiffBits  = SAMPLE_BITS + 1;
	localparam int ProdBits  = SAMPLE_BITS + 18;
	localparam logic signed [ProdBits-1:0] RoundHalf = ProdBits'(1) << (FRAC_BITS - 1);

	logic signed [SAMPLE_BITS-1:0] rom [TableSize];

	logic [TABLE_ADDR_BITS-1:0]   idx;
	logic [TABLE_ADDR_BITS-1:0]   idx_next;
	logic [RestBits+FRAC_BITS-1:0] low_ext;
	logic [FRAC_BITS-1:0]         frac;
	logic                         en;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1;
	logic signed [SAMPLE_BITS-1:0] b_s1;
	logic [FRAC_BITS-1:0]          frac_s1;
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] a_s2;
	logic signed [DiffBits-1:0]    diff_s2;
	logic [FRAC_BITS-1:0]          frac_s2;
	logic                          valid_s3;
	logic signed [SAMPLE_BITS-1:0] a_s3;
	logic signed [ProdBits-1:0]    prod_s3;
	logic signed [ProdBits-1:0]    rounded;
	logic signed [ProdBits-1:0]    total;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	// Sine table contents are fixed at elaboration.
	for (genvar g = 0; g < TableSize; g++) begin : g_rom
		localparam logic signed [31:0] RomVal = rom_entry(g, TABLE_ADDR_BITS, SAMPLE_BITS);
		assign rom[g] = RomVal[SAMPLE_BITS-1:0];
	end

	// Split the phase into table index and a 16-bit interpolation fraction.
	always_comb begin
		idx = pop_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
		idx_next = idx + 1'b1;
		low_ext = {pop_phase[RestBits-1:0], {FRAC_BITS{1'b0}}};
		frac = low_ext[RestBits +: FRAC_BITS];
	end

	// The whole back pipeline moves unless a finished sample is waiting.
	assign en = !out_valid_q || samp.ready;
	assign pop = en && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Table read of both neighbors, registered.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= rom[idx];
			b_s1 <= rom[idx_next];
			frac_s1 <= frac;
		end
	end

	// Difference between the two entries.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			diff_s2 <= DiffBits'(b_s1) - DiffBits'(a_s1);
			frac_s2 <= frac_s1;
		end
	end

	// Scale the difference by the fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= a_s2;
			prod_s3 <= ProdBits'(diff_s2) * ProdBits'(signed'({1'b0, frac_s2}));
		end
	end

	// Round to nearest, ties upward, and add the base entry.
	always_comb begin
		rounded = (prod_s3 + RoundHalf) >>> FRAC_BITS;
		total = ProdBits'(a_s3) + rounded;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= total[SAMPLE_BITS-1:0];
		end
	end

	assign samp.valid = out_valid_q;
	assign samp.sample = sample_q;

endmodule

// ===== sv/sine_table_oscillator_unit.sv =====
// Path: the increment register, the phase queue, then the table read, difference, multiply and output registers.
// Throughput: one item per cycle while the phase queue has room and the sample receiver is ready;
// the phase accumulator adds a registered 24x32 increment product back into itself.
// Reset (arst_n low, asynchronous): phase is zero, sample_period is 89478,
// queue and pipelines are empty. The sine table is constant and needs no fill.
`include "assert_macros.svh"

module sine_table_oscillator_unit import sto_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 11,
	parameter int PHASE_BITS      = 32,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sto_freq_if.sink              freq,
	sto_sample_if.source          samp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	logic [PERIOD_BITS-1:0] sample_period_q;
	logic                   cfg_write;
	sto_q_stat_t            q_stat;
	logic                   push;
	logic                   pop;
	logic [PHASE_BITS-1:0]  push_phase;
	logic [PHASE_BITS-1:0]  pop_phase;

	// Configuration register, written in the APB access phase.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= RESET_PERIOD;
		end else if (cfg_write && paddr[2] == REG_SAMPLE_PERIOD) begin
			sample_period_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_SAMPLE_PERIOD) ? sample_period_q : '0;

	sto_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.freq      (freq),
		.period    (sample_period_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_phase(push_phase)
	);

	sto_queue #(
		.PHASE_BITS(PHASE_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_phase(push_phase),
		.pop       (pop),
		.pop_phase (pop_phase),
		.q_stat    (q_stat)
	);

	sto_back #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS),
		.PHASE_BITS     (PHASE_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_phase(pop_phase),
		.pop      (pop),
		.samp     (samp)
	);

	// The queue is never written when full nor read when empty.
	`STO_NEVER(a_no_overflow, clk, arst_n, push && q_stat.full, "phase queue overflow")
	`STO_NEVER(a_no_underflow, clk, arst_n, pop && q_stat.empty, "phase queue underflow")
	// A waiting result freezes the back part, so nothing leaves the queue.
	`STO_ASSERT(a_stall_holds, clk, arst_n, (samp.valid && !samp.ready) |-> !pop, "pop during stall")

endmodule

// ===== bench/tb_sine_table_oscillator_unit.sv =====
module tb_sine_table_oscillator_unit;
	import sto_pkg::*;

	localparam int SAMPLE_W = 16;
	localparam int ADDR_W = 11;
	localparam int TABLE_DEPTH = 1 << ADDR_W;
	localparam int QUARTER = TABLE_DEPTH / 4;
	localparam longint unsigned SINE_PEAK = 64'd32767;
	localparam longint unsigned HALF_PI = 64'd1686629713;
	localparam int REG_UNUSED = 1;
	localparam int RESULT_LATENCY = 5;
	localparam int RANDOM_PHASE_ITEMS = 190;
	localparam int LONG_HOLD_CYCLES = 150;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [FREQ_BITS-1:0] freq_t;
	typedef logic [PERIOD_BITS-1:0] period_t;

	// Tracks the oscillator phase and the samples it must produce, in order.
	class sine_checker;
		sample_t wave_table [TABLE_DEPTH];
		logic [31:0] phase_turns;
		period_t period_q32;
		sample_t pending_samples [$];
		int mismatches;

		// The table is built from one quarter wave, mirrored and negated.
		function new();
			int quad;
			longint unsigned j;
			longint unsigned k;
			sample_t v;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				quad = (i >> (ADDR_W - 2)) & 3;
				j = i & (QUARTER - 1);
				k = quad[0] ? (QUARTER - j) : j;
				v = quarter_wave(k);
				wave_table[i] = quad[1] ? -v : v;
			end
			phase_turns = '0;
			period_q32 = RESET_PERIOD;
			mismatches = 0;
		endfunction

		// Taylor series of the sine in Q30, scaled to the sample peak.
		function sample_t quarter_wave(longint unsigned k);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned v;
			longint unsigned div;
			longint sum;
			x = (k * HALF_PI + 64'd256) >> 9;
			x2 = (x * x) >> 30;
			t = x;
			sum = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				div = (2 * n) * (2 * n + 1);
				t = ((t * x2) >> 30) / div;
				if (n % 2 == 1) begin
					sum -= longint'(t);
				end else begin
					sum += longint'(t);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (unsigned'(sum) * SINE_PEAK + (64'd1 << 29)) >> 30;
			if (v > SINE_PEAK) begin
				v = SINE_PEAK;
			end
			return sample_t'(v);
		endfunction

		// Interpolate at the current phase, then advance it by one sample period.
		function void note_frequency(freq_t f);
			logic [ADDR_W-1:0] idx;
			logic [ADDR_W-1:0] nxt;
			longint fr;
			longint a;
			longint b;
			longint blend;
			longint unsigned step_prod;
			idx = phase_turns[31:21];
			nxt = idx + 1'b1;
			fr = phase_turns[20:5];
			a = wave_table[idx];
			b = wave_table[nxt];
			blend = a + (((b - a) * fr + 32768) >>> 16);
			pending_samples.push_back(sample_t'(blend));
			step_prod = f;
			step_prod = step_prod * period_q32;
			phase_turns = phase_turns + step_prod[39:8];
		endfunction

		// Compare one sample transfer with the oldest expected sample.
		function void check_sample(sample_t got);
			sample_t want;
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample %0d, expected none", $time, got);
				mismatches++;
			end else begin
				want = pending_samples.pop_front();
				if (got !== want) begin
					$display("%0t: sample expected %0d, actual %0d", $time, want, got);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic pready;

	sto_freq_if freq_ch ();
	sto_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samp_ch ();

	sine_checker chk;
	int samples_seen = 0;
	bit hold_active = 1'b0;
	bit long_hold_done = 1'b0;

	sine_table_oscillator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.freq(freq_ch),
		.samp(samp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Overall time limit for the run.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Every sample transfer is checked against the expected stream.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && samp_ch.valid === 1'b1 && samp_ch.ready === 1'b1) begin
			chk.check_sample(samp_ch.sample);
			samples_seen++;
		end
	end

	// The sample receiver stalls on its own pattern, with one long hold-off.
	initial begin
		int mode;
		int span;
		samp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && samples_seen >= 300 && freq_ch.valid === 1'b1) begin
				long_hold_done = 1'b1;
				hold_active = 1'b1;
				for (int c = 0; c < LONG_HOLD_CYCLES; c++) begin
					samp_ch.ready <= 1'b0;
					@(posedge clk);
				end
				hold_active = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 40);
				for (int c = 0; c < span; c++) begin
					case (mode)
						0: begin
							samp_ch.ready <= 1'b1;
						end
						1: begin
							samp_ch.ready <= ($urandom_range(0, 9) < 7);
						end
						2: begin
							samp_ch.ready <= (c % 3 != 2);
						end
						default: begin
							samp_ch.ready <= (c % 8 == 0);
						end
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offer one frequency and hold it until the transfer happens.
	task automatic send_frequency(input freq_t f);
		freq_ch.valid <= 1'b1;
		freq_ch.frequency <= f;
		do @(posedge clk); while (freq_ch.ready !== 1'b1);
		chk.note_frequency(f);
	endtask

	task automatic idle_freq(input int n);
		freq_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop offering until every expected sample has arrived.
	task automatic drain_results();
		freq_ch.valid <= 1'b0;
		do @(posedge clk); while (chk.pending_samples.size() != 0);
	endtask

	// A register write: setup phase, access phase, then idle with psel low.
	task automatic apb_write(input int index, input logic [PDATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'(index * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (index == REG_SAMPLE_PERIOD) begin
			chk.period_q32 = data;
		end
	endtask

	// Read the sample period back and compare it with the tracked value.
	task automatic apb_check_period();
		logic [PDATA_BITS-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_BITS'(REG_SAMPLE_PERIOD * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== chk.period_q32) begin
			$display("%0t: sample_period expected %0h, actual %0h", $time, chk.period_q32, got);
			chk.mismatches++;
		end
	endtask

	// Registers change only once the block has gone quiet.
	task automatic set_period(input period_t p);
		drain_results();
		repeat (RESULT_LATENCY) @(posedge clk);
		apb_write(REG_SAMPLE_PERIOD, p);
		apb_check_period();
	endtask

	// Mostly full-range frequencies, some audio range and some tiny ones.
	function automatic freq_t random_frequency();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return freq_t'($urandom);
		end else if (pick < 9) begin
			return freq_t'($urandom_range(0, 20000 * 256));
		end
		return freq_t'($urandom_range(0, 255));
	endfunction

	// Bursts of random length, random gaps, and now and then a full drain.
	task automatic random_run(input int count);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left) begin
				burst = left;
			end
			for (int i = 0; i < burst; i++) begin
				send_frequency(random_frequency());
			end
			left -= burst;
			if ($urandom_range(0, 9) == 0 && !hold_active) begin
				drain_results();
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					idle_freq(gap);
				end
			end
		end
	endtask

	initial begin
		period_t periods [6];
		logic [31:0] delta;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		freq_ch.valid <= 1'b0;
		freq_ch.frequency <= '0;
		chk = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes and bit patterns at the reset sample period.
		send_frequency(24'h000000);
		send_frequency(24'h000000);
		send_frequency(24'hFFFFFF);
		send_frequency(24'h000001);
		send_frequency(freq_t'(440 * 256));
		send_frequency(24'h555555);
		send_frequency(24'hAAAAAA);
		send_frequency(24'h800000);
		send_frequency(24'h7FFFFF);
		send_frequency(24'h00FFFF);

		// A write to an index with no register behind it changes nothing.
		drain_results();
		repeat (RESULT_LATENCY) @(posedge clk);
		apb_write(REG_UNUSED, $urandom);
		apb_check_period();

		// Steer the phase into the last table entry so interpolation wraps to entry zero.
		set_period(32'h0100_0000);
		delta = 32'hFFF0_0000 - chk.phase_turns;
		send_frequency(freq_t'(delta[31:16]));
		send_frequency(24'h000000);
		send_frequency(24'h000000);

		// Longest period: huge increments wrap around whole turns.
		set_period(32'hFFFF_FFFF);
		send_frequency(24'hFFFFFF);
		send_frequency(24'h000100);
		send_frequency(24'h800000);
		send_frequency(random_frequency());
		send_frequency(random_frequency());

		// Zero period: the phase holds and the output repeats.
		set_period(32'h0000_0000);
		send_frequency(random_frequency());
		send_frequency(24'hFFFFFF);
		send_frequency(random_frequency());

		// Random traffic under several sample periods.
		periods = '{RESET_PERIOD, period_t'($urandom), 32'hFFFF_FFFF,
			period_t'($urandom_range(1, 4096)), 32'h8000_0000, period_t'($urandom)};
		foreach (periods[i]) begin
			set_period(periods[i]);
			random_run(RANDOM_PHASE_ITEMS);
		end

		drain_results();
		repeat (RESULT_LATENCY + 5) @(posedge clk);
		if (chk.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
